// ----- rtl/core/hcs_pkg.sv -----
// Shared constants for the Hamiltonian cycle search unit.
`timescale 1ns / 1ps

package hcs_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int FIELD_W      = 5;

  localparam logic REQ_ADD_EDGE = 1'b0;
  localparam logic REQ_SOLVE    = 1'b1;

endpackage

// ----- rtl/core/hamiltonian_cycle_search_unit.sv -----
// Top level: adjacency matrix, backtracking sequencer and result strobe.
`timescale 1ns / 1ps

// An add-edge request completes in the cycle it is accepted and busy stays low.
// A solve request raises busy. It then counts the out-edges of each vertex in
// turn to pick the start vertex, which is the lowest vertex with the most
// out-edges. After that it performs search steps, where a step is one
// push or one pop of the path stack, or the final closing check. A single
// shared row unit reads one adjacency row per cycle in both phases. The search
// time grows with the number of partial paths that the backtracking search
// tries. A single vertex takes one out-edge count and one step. When the search
// ends, out_valid pulses for one cycle with out_found, busy falls in the same
// cycle, and the matrix is cleared. The receiver cannot stall: every result
// transfer happens in the cycle that out_valid is high.
module hamiltonian_cycle_search_unit
  import hcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_req_type,
  input  logic [FIELD_W-1:0] in_from_vertex,
  input  logic [FIELD_W-1:0] in_to_vertex,
  output logic               out_valid,
  output logic               out_found,
  input  logic               cfg_we,
  input  logic [FIELD_W-1:0] cfg_data
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_PICK   = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;

  logic [1:0]              state_r;
  logic [FIELD_W-1:0]      vcount_r;
  logic [MAX_VERTICES-1:0] adj_r [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] visited_r;
  logic [VIDX_W-1:0]       top_r;
  logic [FIELD_W-1:0]      cur_r;
  logic [FIELD_W-1:0]      depth_r;
  logic [VIDX_W-1:0]       stk_r [MAX_VERTICES];
  logic [FIELD_W-1:0]      cur_stk_r [MAX_VERTICES];
  logic                    out_valid_r;
  logic                    out_found_r;
  logic [VIDX_W-1:0]       start_r;
  logic [VIDX_W-1:0]       scan_r;
  logic [FIELD_W-1:0]      best_r;

  logic [FIELD_W-1:0]      n_eff;
  logic [MAX_VERTICES:0]   keep_sh;
  logic [MAX_VERTICES-1:0] keep;
  logic [MAX_VERTICES:0]   cur_sh;
  logic [MAX_VERTICES-1:0] ge_mask;
  logic [VIDX_W-1:0]       row_sel;
  logic [MAX_VERTICES-1:0] row;
  logic [MAX_VERTICES-1:0] cand;
  logic [VIDX_W-1:0]       next_v;
  logic                    has_next;
  logic                    at_full;
  logic                    closes;
  logic [FIELD_W-1:0]      push_idx;
  logic [FIELD_W-1:0]      pop_idx;
  logic [FIELD_W-1:0]      pop_cnt;
  logic                    pick_better;
  logic [VIDX_W-1:0]       pick_v;
  logic                    scan_last;
  logic                    accept;
  logic                    edge_ok;
  logic [FIELD_W-1:0]      from_m1;
  logic [FIELD_W-1:0]      to_m1;

  always_comb begin
    if (vcount_r == '0) begin
      n_eff = FIELD_W'(1);
    end else if (vcount_r > FIELD_W'(MAX_VERTICES)) begin
      n_eff = FIELD_W'(MAX_VERTICES);
    end else begin
      n_eff = vcount_r;
    end
  end

  // shared row unit: out-edge count and next-neighbor find
  always_comb begin
    keep_sh  = (MAX_VERTICES + 1)'(1) << n_eff;
    keep     = MAX_VERTICES'(keep_sh - (MAX_VERTICES + 1)'(1));
    cur_sh   = (MAX_VERTICES + 1)'(1) << cur_r;
    ge_mask  = ~MAX_VERTICES'(cur_sh - (MAX_VERTICES + 1)'(1));
    row_sel  = (state_r == ST_PICK) ? scan_r : top_r;
    row      = adj_r[row_sel] & keep;
    pop_cnt  = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      pop_cnt = pop_cnt + FIELD_W'(row[i]);
    end
    pick_better = (pop_cnt > best_r);
    pick_v      = pick_better ? scan_r : start_r;
    scan_last   = (FIELD_W'(scan_r) == n_eff - FIELD_W'(1));
    cand     = row & ~visited_r & ge_mask;
    has_next = |cand;
    next_v   = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        next_v = VIDX_W'(i);
      end
    end
    at_full  = (depth_r == n_eff);
    closes   = row[start_r];
    push_idx = depth_r - FIELD_W'(1);
    pop_idx  = depth_r - FIELD_W'(2);
  end

  assign accept  = start && !busy;
  assign from_m1 = in_from_vertex - FIELD_W'(1);
  assign to_m1   = in_to_vertex - FIELD_W'(1);
  assign edge_ok = (in_from_vertex != '0) && (in_from_vertex <= n_eff) &&
                   (in_to_vertex != '0) && (in_to_vertex <= n_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vcount_r    <= FIELD_W'(1);
      visited_r   <= '0;
      depth_r     <= '0;
      top_r       <= '0;
      cur_r       <= '0;
      start_r     <= '0;
      scan_r      <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
      out_found_r <= 1'b0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        adj_r[i] <= '0;
      end
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        vcount_r <= cfg_data;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_req_type == REQ_ADD_EDGE) begin
              if (edge_ok) begin
                adj_r[from_m1[VIDX_W-1:0]] <= adj_r[from_m1[VIDX_W-1:0]] |
                  (MAX_VERTICES'(1) << to_m1[VIDX_W-1:0]);
              end
            end else begin
              state_r <= ST_PICK;
              scan_r  <= '0;
              best_r  <= '0;
              start_r <= '0;
            end
          end
        end
        ST_PICK: begin
          if (pick_better) begin
            best_r  <= pop_cnt;
            start_r <= scan_r;
          end
          if (scan_last) begin
            state_r   <= ST_SEARCH;
            visited_r <= MAX_VERTICES'(1) << pick_v;
            top_r     <= pick_v;
            cur_r     <= '0;
            depth_r   <= FIELD_W'(1);
          end else begin
            scan_r <= scan_r + VIDX_W'(1);
          end
        end
        ST_SEARCH: begin
          if (at_full && closes) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            out_found_r <= 1'b1;
            visited_r   <= '0;
            depth_r     <= '0;
            for (int i = 0; i < MAX_VERTICES; i++) begin
              adj_r[i] <= '0;
            end
          end else if (!at_full && has_next) begin
            stk_r[push_idx[VIDX_W-1:0]]     <= top_r;
            cur_stk_r[push_idx[VIDX_W-1:0]] <= FIELD_W'(next_v) + FIELD_W'(1);
            visited_r <= visited_r | (MAX_VERTICES'(1) << next_v);
            top_r     <= next_v;
            cur_r     <= '0;
            depth_r   <= depth_r + FIELD_W'(1);
          end else if (depth_r == FIELD_W'(1)) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            out_found_r <= 1'b0;
            visited_r   <= '0;
            depth_r     <= '0;
            for (int i = 0; i < MAX_VERTICES; i++) begin
              adj_r[i] <= '0;
            end
          end else begin
            visited_r <= visited_r & ~(MAX_VERTICES'(1) << top_r);
            top_r     <= stk_r[pop_idx[VIDX_W-1:0]];
            cur_r     <= cur_stk_r[pop_idx[VIDX_W-1:0]];
            depth_r   <= depth_r - FIELD_W'(1);
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_found = out_found_r;

endmodule

// ----- rtl/core/hcs_checker.sv -----
// Port-level checker for the Hamiltonian cycle search unit, with its bind.
`timescale 1ns / 1ps

module hcs_checker
  import hcs_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_req_type,
  input logic out_valid
);

  a_result_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result transfer while busy");

  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_add_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req_type == REQ_ADD_EDGE) |=> (!busy && !out_valid))
    else $error("add edge caused busy or a result");

  a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req_type == REQ_SOLVE) |=> busy)
    else $error("solve did not raise busy");

  a_result_after_search: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(busy))
    else $error("result without a search");

endmodule

bind hamiltonian_cycle_search_unit hcs_checker u_hcs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_req_type (in_req_type),
  .out_valid   (out_valid)
);
